### hdl/typed_field_packet_reader_unit_defines.svh
// Assertion macros used by tfpr_decoder of the typed field packet reader RTL.
// Assumes the including module has clk_i and rst_ni (active low) in scope.
`ifndef TYPED_FIELD_PACKET_READER_UNIT_DEFINES_SVH
`define TYPED_FIELD_PACKET_READER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TFPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tfpr_pkg.sv
// Shared types and constants of the typed field packet reader.
// No dependencies; used by tfpr_decoder and typed_field_packet_reader_unit.
`timescale 1ns / 1ps
`default_nettype none

package tfpr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 16;

  // Field tags
  localparam logic [ByteW-1:0] TagInt  = 8'h49;  // 'I'
  localparam logic [ByteW-1:0] TagLong = 8'h4C;  // 'L'
  localparam logic [ByteW-1:0] TagText = 8'h64;  // 'd'
  localparam logic [ByteW-1:0] TagStr  = 8'h53;  // 'S'

  // Unit size byte codes of a string field
  localparam logic [ByteW-1:0] UnitCode1 = 8'd1;
  localparam logic [ByteW-1:0] UnitCode2 = 8'd2;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_LONG  = 3'd1,
    KIND_TEXT  = 3'd2,
    KIND_STR   = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_TRUNC = 3'd5
  } kind_e;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [ValueW-1:0] value;
    logic              last;
    logic              empty;
  } result_t;

endpackage

`default_nettype wire

### hdl/typed_field_packet_reader_unit.sv
// Top level of the typed field packet reader: stream ports, config register,
// input and result registers. Depends on tfpr_pkg and tfpr_decoder.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a packet of tagged fields ('I', 'L', 'd', 'S') arriving one byte per
// beat on the slave stream and emits at most one result beat per input byte.
// One byte is accepted every cycle unless the output stalls; a byte goes through
// an input register and one pass of decode logic into the result register. The
// result register lets the next byte in while a result waits for the downstream
// side. Write byte_order only while no packet is in flight and the output has
// drained.
module typed_field_packet_reader_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write: byte_order (0 msb first, 1 lsb first)
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // input bytes
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [tfpr_pkg::ByteW-1:0] s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,                  // last_byte
  // results
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [tfpr_pkg::ValueW-1:0] m_axis_tdata_o,       // [63:0] field_value
  output logic             m_axis_tlast_o,                  // last_of_field
  output logic [3:0]       m_axis_tuser_o                   // [2:0] field_kind, [3] empty_field
);
  import tfpr_pkg::*;

  logic              byte_order_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              in_last_q;
  logic              out_valid_q;
  result_t           out_q;
  result_t           res;
  logic              advance;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      byte_order_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  tfpr_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (advance),
    .step_byte_i  (in_byte_q),
    .step_last_i  (in_last_q),
    .byte_order_i (byte_order_q),
    .res_o        (res)
  );

  // result register: load on advance, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.value;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = {out_q.empty, out_q.kind};

endmodule

`default_nettype wire

### hdl/tfpr_decoder.sv
// Parse state and per-byte decode of the typed field packet reader.
// Depends on tfpr_pkg and typed_field_packet_reader_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "typed_field_packet_reader_unit_defines.svh"

module tfpr_decoder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_valid_i,
  input  wire logic [tfpr_pkg::ByteW-1:0] step_byte_i,
  input  wire logic                      step_last_i,
  input  wire logic                      byte_order_i,
  output tfpr_pkg::result_t              res_o
);
  import tfpr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_INT   = 3'd1,
    PH_DLEN  = 3'd2,
    PH_DCHR  = 3'd3,
    PH_SHI   = 3'd4,
    PH_SLO   = 3'd5,
    PH_SSIZE = 3'd6,
    PH_SCHR  = 3'd7
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [ValueW-1:0]   asm_q, asm_d;
  logic [CountW-1:0]   left_q, left_d;
  logic [1:0]          upos_q, upos_d;
  logic [1:0]          usize_q, usize_d;
  logic                long_q, long_d;
  logic                err_q, err_d;

  logic [CountW-1:0]   left_m1;
  logic [2:0]          le_idx;
  logic [3:0]          total;
  logic [ByteW-1:0]    chr;
  logic                incomplete;
  result_t             res;

  assign left_m1 = left_q - CountW'(1);
  assign total   = long_q ? 4'd8 : 4'd4;
  assign le_idx  = 3'(total - left_q[3:0]);
  assign chr     = (upos_q == 2'd0) ? step_byte_i : asm_q[ByteW-1:0];

  always_comb begin
    phase_d    = phase_q;
    asm_d      = asm_q;
    left_d     = left_q;
    upos_d     = upos_q;
    usize_d    = usize_q;
    long_d     = long_q;
    err_d      = err_q;
    incomplete = 1'b0;
    res        = '0;
    res.kind   = KIND_INT;

    if (step_valid_i) begin
      if (err_q) begin
        // drop bytes until the packet ends
        if (step_last_i) begin
          err_d   = 1'b0;
          phase_d = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            asm_d      = '0;
            incomplete = 1'b1;
            if (step_byte_i == TagInt) begin
              long_d  = 1'b0;
              left_d  = CountW'(4);
              phase_d = PH_INT;
            end else if (step_byte_i == TagLong) begin
              long_d  = 1'b1;
              left_d  = CountW'(8);
              phase_d = PH_INT;
            end else if (step_byte_i == TagText) begin
              phase_d = PH_DLEN;
            end else if (step_byte_i == TagStr) begin
              phase_d = PH_SHI;
            end else begin
              incomplete = 1'b0;
              err_d      = !step_last_i;
              res.valid  = 1'b1;
              res.kind   = KIND_ERR;
              res.value  = ValueW'(step_byte_i);
              res.last   = 1'b1;
            end
          end
          PH_INT: begin
            if (byte_order_i) begin
              asm_d = asm_q | (ValueW'(step_byte_i) << {le_idx, 3'b000});
            end else begin
              asm_d = {asm_q[ValueW-ByteW-1:0], step_byte_i};
            end
            left_d = left_m1;
            if (left_m1 == '0) begin
              phase_d   = PH_IDLE;
              res.valid = 1'b1;
              res.last  = 1'b1;
              if (long_q) begin
                res.kind  = KIND_LONG;
                res.value = asm_d;
              end else begin
                res.kind  = KIND_INT;
                res.value = {{32{asm_d[31]}}, asm_d[31:0]};
              end
            end else begin
              incomplete = 1'b1;
            end
          end
          PH_DLEN: begin
            left_d = CountW'(step_byte_i);
            if (step_byte_i == '0) begin
              phase_d   = PH_IDLE;
              res.valid = 1'b1;
              res.kind  = KIND_TEXT;
              res.last  = 1'b1;
              res.empty = 1'b1;
            end else begin
              phase_d    = PH_DCHR;
              incomplete = 1'b1;
            end
          end
          PH_DCHR: begin
            left_d    = left_m1;
            res.valid = 1'b1;
            res.kind  = KIND_TEXT;
            res.value = ValueW'(step_byte_i);
            if (left_m1 == '0) begin
              phase_d  = PH_IDLE;
              res.last = 1'b1;
            end else begin
              incomplete = 1'b1;
            end
          end
          PH_SHI: begin
            asm_d      = ValueW'(step_byte_i);
            phase_d    = PH_SLO;
            incomplete = 1'b1;
          end
          PH_SLO: begin
            left_d     = {asm_q[ByteW-1:0], step_byte_i};
            phase_d    = PH_SSIZE;
            incomplete = 1'b1;
          end
          PH_SSIZE: begin
            if (step_byte_i == UnitCode1) begin
              usize_d = 2'd0;
            end else if (step_byte_i == UnitCode2) begin
              usize_d = 2'd1;
            end else begin
              usize_d = 2'd3;
            end
            upos_d = 2'd0;
            if (left_q == '0) begin
              phase_d   = PH_IDLE;
              res.valid = 1'b1;
              res.kind  = KIND_STR;
              res.last  = 1'b1;
              res.empty = 1'b1;
            end else begin
              phase_d    = PH_SCHR;
              incomplete = 1'b1;
            end
          end
          PH_SCHR: begin
            // keep the first byte of each unit
            if (upos_q == 2'd0) begin
              asm_d = ValueW'(step_byte_i);
            end
            if (upos_q >= usize_q) begin
              upos_d    = 2'd0;
              left_d    = left_m1;
              res.valid = 1'b1;
              res.kind  = KIND_STR;
              res.value = ValueW'(chr);
              if (left_m1 == '0) begin
                phase_d  = PH_IDLE;
                res.last = 1'b1;
              end else begin
                incomplete = 1'b1;
              end
            end else begin
              upos_d     = upos_q + 2'd1;
              incomplete = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        // packet ended inside a field: report truncation instead
        if (step_last_i && incomplete) begin
          phase_d   = PH_IDLE;
          res       = '0;
          res.valid = 1'b1;
          res.kind  = KIND_TRUNC;
          res.last  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      asm_q   <= '0;
      left_q  <= '0;
      upos_q  <= '0;
      usize_q <= '0;
      long_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      asm_q   <= asm_d;
      left_q  <= left_d;
      upos_q  <= upos_d;
      usize_q <= usize_d;
      long_q  <= long_d;
      err_q   <= err_d;
    end
  end

  assign res_o = res;

  `TFPR_ASSERT_IMP(a_err_silent, step_valid_i && err_q, !res_o.valid,
                   "result produced while a tag error is latched")
  `TFPR_ASSERT_IMP(a_trunc_on_last, res_o.valid && (res_o.kind == KIND_TRUNC), step_last_i,
                   "truncation reported on a byte that does not end the packet")
  `TFPR_ASSERT_IMP(a_empty_shape, res_o.valid && res_o.empty,
                   res_o.last && (res_o.value == '0) &&
                   ((res_o.kind == KIND_TEXT) || (res_o.kind == KIND_STR)),
                   "malformed empty field result")
  `TFPR_ASSERT_NXT(a_idle_after_last, step_valid_i && step_last_i,
                   (phase_q == PH_IDLE) && !err_q,
                   "reader not idle after the packet end")

endmodule

`default_nettype wire
